FILE: hdl/lspq_pkg.sv
// Shared types, constants and helpers for the linear scan priority queue.
`default_nettype none

package lspq_pkg;

  // Store sizing
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned COUNT_W  = 7;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // Input request queue between front and back
  localparam int unsigned FQ_DEPTH = 2;
  localparam int unsigned FQ_PTR_W = 1;

  // Request type codes
  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_ENQ = 2'd0;
  localparam logic [1:0] ST_DEQ = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;
  localparam logic [1:0] ST_UNF = 2'd3;

  typedef enum logic {
    OP_ENQ,
    OP_DEQ
  } op_e;

  typedef struct packed {
    logic               req_type;
    logic signed [15:0] in_priority;
    logic signed [31:0] in_value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] out_priority;
    logic signed [31:0] out_value;
    logic [COUNT_W-1:0] entry_count;
  } res_t;

  typedef struct packed {
    logic signed [15:0] prio;
    logic signed [31:0] val;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    op_e    op;
    entry_t entry;
  } cmd_t;

  // Report the low bits of the entry count
  function automatic logic [COUNT_W-1:0] count_out(logic [CNT_W-1:0] c);
    logic [CNT_W+COUNT_W-1:0] w;
    w = {{COUNT_W{1'b0}}, c};
    return w[COUNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/linear_scan_priority_queue.sv
// Top level of the bounded min-priority queue with a linear scan store.
// Each result is held in the result register of the back end until it is popped.
// A dequeue scans the stored entries for the minimum and then shifts the entries above it down,
// walks set by the single read port of the entry RAM.
// Throughput: one enqueue per cycle while results are popped; a dequeue holds the back end until its shift ends.
// Reset clears the count and queues at once; the entry RAM is not cleared.
`default_nettype none

module linear_scan_priority_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push,
  output      logic           full,
  input  wire lspq_pkg::req_t req_i,
  output      logic           empty,
  input  wire logic           pop,
  output      lspq_pkg::res_t res_o
);

  logic           cmd_valid;
  logic           cmd_take;
  lspq_pkg::cmd_t cmd;

  lspq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  lspq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .empty_o     (empty),
    .res_o       (res_o),
    .pop_i       (pop)
  );

endmodule

`default_nettype wire

FILE: hdl/lspq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module lspq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write on enable, register every read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: hdl/lspq_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
`default_nettype none

module lspq_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  output      logic          full_o,
  input  wire lspq_pkg::req_t req_i,
  output      logic          cmd_valid_o,
  output      lspq_pkg::cmd_t cmd_o,
  input  wire logic          cmd_take_i
);

  lspq_pkg::cmd_t                  fq_q [lspq_pkg::FQ_DEPTH];
  logic [lspq_pkg::FQ_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [lspq_pkg::FQ_PTR_W:0]     fill_q;
  logic                            push_acc;
  logic                            take_acc;
  lspq_pkg::cmd_t                  cmd_new;

  assign full_o      = (fill_q == (lspq_pkg::FQ_PTR_W + 1)'(lspq_pkg::FQ_DEPTH));
  assign cmd_valid_o = (fill_q != '0);
  assign cmd_o       = fq_q[rd_ptr_q];
  assign push_acc    = push_i && !full_o;
  assign take_acc    = cmd_take_i && cmd_valid_o;

  // Classify the incoming beat
  always_comb begin
    cmd_new.op          = (req_i.req_type == lspq_pkg::REQ_DEQ) ? lspq_pkg::OP_DEQ
                                                                : lspq_pkg::OP_ENQ;
    cmd_new.entry.prio  = req_i.in_priority;
    cmd_new.entry.val   = req_i.in_value;
  end

  // Hold queued commands
  always_ff @(posedge clk_i) begin
    if (push_acc) begin
      fq_q[wr_ptr_q] <= cmd_new;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_acc) begin
        wr_ptr_q <= wr_ptr_q + lspq_pkg::FQ_PTR_W'(1);
      end
      if (take_acc) begin
        rd_ptr_q <= rd_ptr_q + lspq_pkg::FQ_PTR_W'(1);
      end
      if (push_acc && !take_acc) begin
        fill_q <= fill_q + (lspq_pkg::FQ_PTR_W + 1)'(1);
      end else if (take_acc && !push_acc) begin
        fill_q <= fill_q - (lspq_pkg::FQ_PTR_W + 1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/lspq_back.sv
// Back end: executes queued commands on the entry store and holds the result.
`default_nettype none

module lspq_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  input  wire lspq_pkg::cmd_t cmd_i,
  output      logic           cmd_take_o,
  output      logic           empty_o,
  output      lspq_pkg::res_t res_o,
  input  wire logic           pop_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_e;

  state_e                          state_q, state_d;
  logic [lspq_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic [lspq_pkg::ADDR_W-1:0]     idx_q, idx_d;
  logic [lspq_pkg::ADDR_W-1:0]     best_idx_q, best_idx_d;
  lspq_pkg::entry_t                best_q, best_d;
  lspq_pkg::res_t                  res_q, res_d;
  logic                            res_valid_q, res_valid_d;
  logic                            res_load;

  logic                            ram_we;
  logic [lspq_pkg::ADDR_W-1:0]     ram_waddr, ram_raddr;
  logic [lspq_pkg::ENTRY_W-1:0]    ram_wdata, ram_rdata;
  lspq_pkg::entry_t                rd_entry;

  logic                            res_free;
  logic                            idx_last;
  logic [lspq_pkg::ADDR_W-1:0]     idx_inc;
  logic                            take_new;
  lspq_pkg::entry_t                best_n;
  logic [lspq_pkg::ADDR_W-1:0]     best_idx_n;

  lspq_ram #(
    .WIDTH (lspq_pkg::ENTRY_W),
    .DEPTH (lspq_pkg::CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_entry   = lspq_pkg::entry_t'(ram_rdata);
  assign empty_o    = !res_valid_q;
  assign res_o      = res_q;
  assign res_free   = !res_valid_q || pop_i;
  assign cmd_take_o = (state_q == S_IDLE) && cmd_valid_i && res_free;
  assign idx_last   = (lspq_pkg::CNT_W'(idx_q) == (cnt_q - lspq_pkg::CNT_W'(1)));
  assign idx_inc    = idx_q + lspq_pkg::ADDR_W'(1);

  // Keep the earliest strict minimum seen so far
  assign take_new   = (idx_q == '0) || (rd_entry.prio < best_q.prio);
  assign best_n     = take_new ? rd_entry : best_q;
  assign best_idx_n = take_new ? idx_q : best_idx_q;

  // Sequence enqueue, scan and shift
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    res_d      = res_q;
    res_load   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = idx_q;
    ram_wdata  = ram_rdata;
    ram_raddr  = idx_inc;

    case (state_q)
      S_IDLE: begin
        if (cmd_take_o) begin
          res_d.out_priority = '0;
          res_d.out_value    = '0;
          res_d.entry_count  = lspq_pkg::count_out(cnt_q);
          if (cmd_i.op == lspq_pkg::OP_ENQ) begin
            res_load = 1'b1;
            if (cnt_q == lspq_pkg::CAP_CNT) begin
              res_d.status = lspq_pkg::ST_OVF;
            end else begin
              ram_we            = 1'b1;
              ram_waddr         = lspq_pkg::ADDR_W'(cnt_q);
              ram_wdata         = cmd_i.entry;
              cnt_d             = cnt_q + lspq_pkg::CNT_W'(1);
              res_d.status      = lspq_pkg::ST_ENQ;
              res_d.entry_count = lspq_pkg::count_out(cnt_q + lspq_pkg::CNT_W'(1));
            end
          end else if (cnt_q == '0) begin
            res_load     = 1'b1;
            res_d.status = lspq_pkg::ST_UNF;
          end else begin
            ram_raddr = '0;
            idx_d     = '0;
            state_d   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        best_d     = best_n;
        best_idx_d = best_idx_n;
        if (idx_last) begin
          idx_d     = best_idx_n;
          ram_raddr = best_idx_n + lspq_pkg::ADDR_W'(1);
          state_d   = S_SHIFT;
        end else begin
          idx_d     = idx_inc;
          ram_raddr = idx_inc;
        end
      end
      S_SHIFT: begin
        if (idx_last) begin
          cnt_d              = cnt_q - lspq_pkg::CNT_W'(1);
          res_load           = 1'b1;
          res_d.status       = lspq_pkg::ST_DEQ;
          res_d.out_priority = best_q.prio;
          res_d.out_value    = best_q.val;
          res_d.entry_count  = lspq_pkg::count_out(cnt_q - lspq_pkg::CNT_W'(1));
          state_d            = S_IDLE;
        end else begin
          // Move the next entry down one place
          ram_we    = 1'b1;
          ram_waddr = idx_q;
          ram_wdata = ram_rdata;
          idx_d     = idx_inc;
          ram_raddr = idx_q + lspq_pkg::ADDR_W'(2);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Load a result or drop it once popped
  always_comb begin
    res_valid_d = res_valid_q;
    if (res_load) begin
      res_valid_d = 1'b1;
    end else if (pop_i && res_valid_q) begin
      res_valid_d = 1'b0;
    end
  end

  // Hold state and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      best_idx_q  <= '0;
      best_q      <= '0;
      res_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      best_idx_q  <= best_idx_d;
      best_q      <= best_d;
      res_q       <= res_d;
      res_valid_q <= res_valid_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= lspq_pkg::CAP_CNT)
    else $error("entry count above capacity");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_SHIFT) |-> (lspq_pkg::CNT_W'(idx_q) < cnt_q))
    else $error("scan or shift index beyond stored entries");

  a_res_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!res_valid_q || pop_i))
    else $error("result overwritten before pop");

  a_deq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT && idx_last) |=> (cnt_q == $past(cnt_q) - lspq_pkg::CNT_W'(1)))
    else $error("dequeue did not drop exactly one entry");

endmodule

`default_nettype wire
